// File: hdl/mvvl_pkg.sv
// Shared types, constants and register map for the two-motor velocity command
// and voltage limiter. No dependencies; used by every module in hdl/.
`default_nettype none

package mvvl_pkg;

    localparam int MOTOR_COUNT       = 2;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int CFG_ADDR_W        = 5;

    localparam logic REQ_COMMAND = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    localparam logic [2:0] REG_MAX_SLEW      = 3'd0;
    localparam logic [2:0] REG_MAX_SPEED     = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN     = 3'd2;
    localparam logic [2:0] REG_FF_GAIN       = 3'd3;
    localparam logic [2:0] REG_BASE_VOLTAGE  = 3'd4;
    localparam logic [2:0] REG_BOOST_VOLTAGE = 3'd5;
    localparam logic [2:0] REG_SUPPLY        = 3'd6;
    localparam logic [2:0] REG_TIMEOUT       = 3'd7;

    localparam logic [30:0] RST_MAX_SLEW      = 31'd6553600;
    localparam logic [30:0] RST_MAX_SPEED     = 31'd8519680;
    localparam logic [30:0] RST_PROP_GAIN     = 31'd32768;
    localparam logic [30:0] RST_FF_GAIN       = 31'd3277;
    localparam logic [30:0] RST_BASE_VOLTAGE  = 31'd98304;
    localparam logic [30:0] RST_BOOST_VOLTAGE = 31'd327680;
    localparam logic [30:0] RST_SUPPLY        = 31'd786432;
    localparam logic [15:0] RST_TIMEOUT       = 16'd500;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] target_vel_a;
        logic signed [31:0] target_vel_b;
        logic signed [31:0] measured_vel_a;
        logic signed [31:0] measured_vel_b;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] vel_cmd_a;
        logic signed [31:0] vel_cmd_b;
        logic        [30:0] volt_limit_a;
        logic        [30:0] volt_limit_b;
        logic               timed_out;
    } out_word_t;

    typedef struct packed {
        logic [30:0] max_slew;
        logic [30:0] max_speed;
        logic [30:0] prop_gain;
        logic [30:0] feedforward_gain;
        logic [30:0] base_voltage;
        logic [30:0] boost_voltage;
        logic [30:0] supply_voltage;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic load;
        logic commit;
        logic kill;
    } lane_ctrl_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] vel_cmd;
        logic        [30:0] volt_limit;
    } lane_result_t;

    typedef struct packed {
        logic load;
        logic commit;
    } merge_ctrl_t;

    typedef enum logic [2:0] {
        LANE_IDLE,
        LANE_PREP,
        LANE_EST,
        LANE_CORR,
        LANE_FIX,
        LANE_MULT,
        LANE_LIMIT,
        LANE_DONE
    } lane_state_e;

    typedef enum logic {
        CORE_IDLE,
        CORE_BUSY
    } core_state_e;

endpackage

`default_nettype wire

// File: hdl/mvvl_lane.sv
// One motor lane: IIR average with a reciprocal-multiply divide, slew and clamp
// of the command, and the voltage limit. Depends on mvvl_pkg.
`default_nettype none

module mvvl_lane #(
    parameter int FRAC_BITS = mvvl_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mvvl_pkg::cfg_t        cfg,
    input  wire mvvl_pkg::lane_ctrl_t  ctrl,
    input  wire logic signed [31:0]    target_vel,
    input  wire logic signed [31:0]    meas_vel,
    output mvvl_pkg::lane_result_t     result
);

    localparam longint unsigned ONE_FX      = 64'd1 << FRAC_BITS;
    localparam longint unsigned GAIN_FX     = (ONE_FX + 64'd50) / 64'd100;
    localparam longint unsigned DEADBAND_FX = (ONE_FX + 64'd5) / 64'd10;
    localparam longint unsigned DESIGN_FX   = 64'd10 * ONE_FX;
    localparam longint unsigned DIVISOR_FX  = ONE_FX + GAIN_FX;
    localparam longint unsigned RECIP_FX    = (64'd1 << (FRAC_BITS + 32)) / DIVISOR_FX;
    localparam int GAIN_W = $clog2(GAIN_FX + 1);
    localparam int DIV_W  = $clog2(DIVISOR_FX + 1);
    localparam int PROD_W = 33 + GAIN_W;
    localparam int SUM_W  = 34;
    localparam int NUM_W  = 32 + FRAC_BITS;
    localparam int LSUM_W = 66;

    localparam logic [GAIN_W-1:0]  GAIN_C     = GAIN_W'(GAIN_FX);
    localparam logic [DIV_W-1:0]   DIV_C      = DIV_W'(DIVISOR_FX);
    localparam logic [31:0]        RECIP_C    = 32'(RECIP_FX);
    localparam logic signed [32:0] DEADBAND_C = 33'(DEADBAND_FX);
    localparam logic signed [32:0] DESIGN_C   = 33'(DESIGN_FX);

    mvvl_pkg::lane_state_e state_reg, state_next;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [31:0]       cmd_new_reg;
    logic signed [31:0]       target_reg;
    logic signed [31:0]       avg_reg;
    logic signed [31:0]       cmd_reg;
    logic signed [31:0]       avg_new_reg;
    logic [31:0]              num_reg;
    logic [31:0]              quo_reg;
    logic [NUM_W-1:0]         rem_reg;
    logic                     neg_reg;
    logic [63:0]              p1_reg, p2_reg;
    logic                     outside_reg, lag_reg;
    logic [30:0]              lim_reg;

    // slew and clamp of the command, and the gain product
    logic signed [32:0] err;
    logic [32:0]        err_mag;
    logic signed [33:0] slew_s, speed_s, slewed, clamped;
    logic signed [31:0] cmd_new_next;
    logic signed [PROD_W-1:0] prod_next;

    always_comb begin
        err     = 33'(target_reg) - 33'(cmd_reg);
        err_mag = err[32] ? 33'(-err) : 33'(err);
        slew_s  = $signed({3'b000, cfg.max_slew});
        speed_s = $signed({3'b000, cfg.max_speed});
        if (err_mag < {2'b00, cfg.max_slew}) begin
            slewed = 34'(target_reg);
        end else if (!err[32]) begin
            slewed = 34'(cmd_reg) + slew_s;
        end else begin
            slewed = 34'(cmd_reg) - slew_s;
        end
        if (slewed > speed_s) begin
            clamped = speed_s;
        end else if (slewed < -speed_s) begin
            clamped = -speed_s;
        end else begin
            clamped = slewed;
        end
        cmd_new_next = clamped[31:0];
        prod_next    = meas_vel * $signed({1'b0, GAIN_C});
    end

    // average numerator, magnitude always below 2^32
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        sum_mag;

    always_comb begin
        sum     = SUM_W'(avg_reg) + SUM_W'($signed(prod_reg[PROD_W-1:FRAC_BITS]));
        sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    end

    // estimate is exact or one low; the remainder decides the round-up
    logic [63:0]      est_prod;
    logic [NUM_W-1:0] back_prod;
    logic [NUM_W-1:0] rem_next;
    logic             round_up;
    logic [32:0]      quo_fix;

    always_comb begin
        est_prod  = 64'(num_reg) * 64'(RECIP_C);
        back_prod = NUM_W'(quo_reg) * NUM_W'(DIV_C);
        rem_next  = {num_reg, {FRAC_BITS{1'b0}}} - back_prod;
        round_up  = rem_reg >= NUM_W'(DIV_C);
        quo_fix   = {1'b0, quo_reg} + {32'd0, round_up};
    end

    // quotient sign and saturation
    logic signed [SUM_W-1:0] quo_s;
    logic signed [31:0]      avg_new_next;

    always_comb begin
        quo_s = neg_reg ? -$signed({1'b0, quo_fix}) : $signed({1'b0, quo_fix});
        if (quo_s > 34'sd2147483647) begin
            avg_new_next = 32'sh7FFF_FFFF;
        end else if (quo_s < -34'sd2147483648) begin
            avg_new_next = 32'sh8000_0000;
        end else begin
            avg_new_next = quo_s[31:0];
        end
    end

    // limit terms
    logic signed [32:0] d1, d2, cmd33, avg2;
    logic [32:0]        m1, m2;
    logic [63:0]        p1_next, p2_next;
    logic               outside_next, lag_next;

    always_comb begin
        cmd33        = 33'(cmd_new_reg);
        avg2         = {avg_new_reg, 1'b0};
        d1           = cmd33 - 33'(avg_new_reg);
        d2           = cmd33 - DESIGN_C;
        m1           = d1[32] ? 33'(-d1) : 33'(d1);
        m2           = d2[32] ? 33'(-d2) : 33'(d2);
        p1_next      = 64'(m1) * 64'(cfg.prop_gain);
        p2_next      = 64'(m2) * 64'(cfg.feedforward_gain);
        outside_next = (cmd33 > DEADBAND_C) || (cmd33 < -DEADBAND_C);
        lag_next     = (cmd33 > 33'sd0) ? (avg2 < cmd33) : (avg2 > cmd33);
    end

    logic [LSUM_W-1:0] lim_sum;
    logic [30:0]       lim_next;

    always_comb begin
        lim_sum = LSUM_W'(p1_reg >> FRAC_BITS) + LSUM_W'(p2_reg >> FRAC_BITS)
                + LSUM_W'(cfg.base_voltage)
                + (lag_reg ? LSUM_W'(cfg.boost_voltage) : LSUM_W'(0));
        if (!outside_reg) begin
            lim_next = '0;
        end else if (lim_sum > LSUM_W'(cfg.supply_voltage)) begin
            lim_next = cfg.supply_voltage;
        end else begin
            lim_next = lim_sum[30:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mvvl_pkg::LANE_IDLE: begin
                if (ctrl.start) begin
                    state_next = mvvl_pkg::LANE_PREP;
                end
            end
            mvvl_pkg::LANE_PREP:  state_next = mvvl_pkg::LANE_EST;
            mvvl_pkg::LANE_EST:   state_next = mvvl_pkg::LANE_CORR;
            mvvl_pkg::LANE_CORR:  state_next = mvvl_pkg::LANE_FIX;
            mvvl_pkg::LANE_FIX:   state_next = mvvl_pkg::LANE_MULT;
            mvvl_pkg::LANE_MULT:  state_next = mvvl_pkg::LANE_LIMIT;
            mvvl_pkg::LANE_LIMIT: state_next = mvvl_pkg::LANE_DONE;
            mvvl_pkg::LANE_DONE: begin
                if (ctrl.commit) begin
                    state_next = mvvl_pkg::LANE_IDLE;
                end
            end
            default: state_next = mvvl_pkg::LANE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mvvl_pkg::LANE_IDLE;
            avg_reg    <= '0;
            cmd_reg    <= '0;
            target_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (ctrl.load) begin
                target_reg <= target_vel;
            end
            if (ctrl.commit) begin
                avg_reg <= avg_new_reg;
                cmd_reg <= ctrl.kill ? 32'sd0 : cmd_new_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            mvvl_pkg::LANE_IDLE: begin
                if (ctrl.start) begin
                    prod_reg    <= prod_next;
                    cmd_new_reg <= cmd_new_next;
                end
            end
            mvvl_pkg::LANE_PREP: begin
                num_reg <= sum_mag[31:0];
                neg_reg <= sum[SUM_W-1];
            end
            mvvl_pkg::LANE_EST: begin
                quo_reg <= est_prod[63:32];
            end
            mvvl_pkg::LANE_CORR: begin
                rem_reg <= rem_next;
            end
            mvvl_pkg::LANE_FIX: begin
                avg_new_reg <= avg_new_next;
            end
            mvvl_pkg::LANE_MULT: begin
                p1_reg      <= p1_next;
                p2_reg      <= p2_next;
                outside_reg <= outside_next;
                lag_reg     <= lag_next;
            end
            mvvl_pkg::LANE_LIMIT: begin
                lim_reg <= lim_next;
            end
            default: begin
            end
        endcase
    end

    assign result.done       = (state_reg == mvvl_pkg::LANE_DONE);
    assign result.vel_cmd    = cmd_new_reg;
    assign result.volt_limit = lim_reg;

endmodule

`default_nettype wire

// File: hdl/mvvl_merge.sv
// Merging stage: command timeout, kill of the outputs, and the result word
// register on the m_ channel. Depends on mvvl_pkg.
`default_nettype none

module mvvl_merge (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire mvvl_pkg::merge_ctrl_t  ctrl,
    input  wire logic [15:0]            timeout_ticks,
    input  wire mvvl_pkg::lane_result_t lane_res [mvvl_pkg::MOTOR_COUNT],
    input  wire logic                   m_ready,
    output logic                        m_valid,
    output mvvl_pkg::out_word_t         m_data,
    output logic                        kill,
    output logic                        out_free
);

    logic [15:0]         ticks_reg, ticks_next;
    logic                expired_reg;
    logic                m_valid_reg;
    mvvl_pkg::out_word_t m_data_reg, m_data_next;

    always_comb begin
        ticks_next = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
        kill       = expired_reg || (ticks_next >= timeout_ticks);
        out_free   = !m_valid_reg || m_ready;

        m_data_next.vel_cmd_a    = kill ? 32'sd0 : lane_res[0].vel_cmd;
        m_data_next.vel_cmd_b    = kill ? 32'sd0 : lane_res[1].vel_cmd;
        m_data_next.volt_limit_a = kill ? 31'd0 : lane_res[0].volt_limit;
        m_data_next.volt_limit_b = kill ? 31'd0 : lane_res[1].volt_limit;
        m_data_next.timed_out    = kill;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg   <= '0;
            expired_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctrl.load) begin
                ticks_reg   <= '0;
                expired_reg <= 1'b0;
            end else if (ctrl.commit) begin
                ticks_reg   <= ticks_next;
                expired_reg <= kill;
            end
            if (ctrl.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: hdl/motor_velocity_voltage_limiter_core.sv
// Top level of the two-motor velocity command and voltage limiter: APB register
// file, sequencing, two mvvl_lane instances and mvvl_merge. Depends on mvvl_pkg.
//
// Usage:
//   s_ channel (valid/ready) takes one in_word_t per word. A command word
//   (req_type 0) latches both targets and restarts the timeout in the cycle it
//   is accepted and produces no result. A tick word (req_type 1) produces one
//   out_word_t on the m_ channel.
//   A tick runs through both lanes in parallel: gain product and slew, the
//   average numerator, the reciprocal multiply and its remainder, then
//   round-up, multiply and limit steps: the result is registered once the
//   lanes finish and the result register is free, and s_ready returns with
//   it, so the block takes no new word while a tick runs through the lanes.
//   Commands in between are taken while the block is idle.
//   The result register parts the two sides: the next word is accepted while a
//   result waits. If m_ready stays low, a finished tick holds in the lanes
//   until the result register frees, and no further word is accepted then.
//   Reset (aresetn low, synchronous) restores register defaults, clears
//   averages, commands and targets, and starts the block timed out.
//   Configuration must be written over APB only while the block is idle; the block does not enforce it.
`default_nettype none

module motor_velocity_voltage_limiter_core #(
    parameter int FRAC_BITS = mvvl_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire mvvl_pkg::in_word_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output mvvl_pkg::out_word_t                  m_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mvvl_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    mvvl_pkg::cfg_t cfg_reg;
    logic           cfg_wr;
    logic [2:0]     cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[mvvl_pkg::CFG_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_slew         <= mvvl_pkg::RST_MAX_SLEW;
            cfg_reg.max_speed        <= mvvl_pkg::RST_MAX_SPEED;
            cfg_reg.prop_gain        <= mvvl_pkg::RST_PROP_GAIN;
            cfg_reg.feedforward_gain <= mvvl_pkg::RST_FF_GAIN;
            cfg_reg.base_voltage     <= mvvl_pkg::RST_BASE_VOLTAGE;
            cfg_reg.boost_voltage    <= mvvl_pkg::RST_BOOST_VOLTAGE;
            cfg_reg.supply_voltage   <= mvvl_pkg::RST_SUPPLY;
            cfg_reg.timeout_ticks    <= mvvl_pkg::RST_TIMEOUT;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                mvvl_pkg::REG_MAX_SLEW:      cfg_reg.max_slew         <= pwdata[30:0];
                mvvl_pkg::REG_MAX_SPEED:     cfg_reg.max_speed        <= pwdata[30:0];
                mvvl_pkg::REG_PROP_GAIN:     cfg_reg.prop_gain        <= pwdata[30:0];
                mvvl_pkg::REG_FF_GAIN:       cfg_reg.feedforward_gain <= pwdata[30:0];
                mvvl_pkg::REG_BASE_VOLTAGE:  cfg_reg.base_voltage     <= pwdata[30:0];
                mvvl_pkg::REG_BOOST_VOLTAGE: cfg_reg.boost_voltage    <= pwdata[30:0];
                mvvl_pkg::REG_SUPPLY:        cfg_reg.supply_voltage   <= pwdata[30:0];
                mvvl_pkg::REG_TIMEOUT:       cfg_reg.timeout_ticks    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            mvvl_pkg::REG_MAX_SLEW:      prdata = {1'b0, cfg_reg.max_slew};
            mvvl_pkg::REG_MAX_SPEED:     prdata = {1'b0, cfg_reg.max_speed};
            mvvl_pkg::REG_PROP_GAIN:     prdata = {1'b0, cfg_reg.prop_gain};
            mvvl_pkg::REG_FF_GAIN:       prdata = {1'b0, cfg_reg.feedforward_gain};
            mvvl_pkg::REG_BASE_VOLTAGE:  prdata = {1'b0, cfg_reg.base_voltage};
            mvvl_pkg::REG_BOOST_VOLTAGE: prdata = {1'b0, cfg_reg.boost_voltage};
            mvvl_pkg::REG_SUPPLY:        prdata = {1'b0, cfg_reg.supply_voltage};
            mvvl_pkg::REG_TIMEOUT:       prdata = {16'd0, cfg_reg.timeout_ticks};
            default:                     prdata = '0;
        endcase
    end

    mvvl_pkg::core_state_e  state_reg, state_next;
    mvvl_pkg::lane_ctrl_t   lane_ctrl;
    mvvl_pkg::merge_ctrl_t  merge_ctrl;
    mvvl_pkg::lane_result_t lane_res [mvvl_pkg::MOTOR_COUNT];
    logic signed [31:0]     target_vel [mvvl_pkg::MOTOR_COUNT];
    logic signed [31:0]     meas_vel   [mvvl_pkg::MOTOR_COUNT];
    logic                   accept, all_done, kill, out_free;

    assign target_vel[0] = s_data.target_vel_a;
    assign target_vel[1] = s_data.target_vel_b;
    assign meas_vel[0]   = s_data.measured_vel_a;
    assign meas_vel[1]   = s_data.measured_vel_b;
    assign all_done      = lane_res[0].done && lane_res[1].done;

    always_comb begin
        state_next        = state_reg;
        s_ready           = 1'b0;
        accept            = 1'b0;
        lane_ctrl.start   = 1'b0;
        lane_ctrl.load    = 1'b0;
        lane_ctrl.commit  = 1'b0;
        lane_ctrl.kill    = kill;
        merge_ctrl.load   = 1'b0;
        merge_ctrl.commit = 1'b0;
        unique case (state_reg)
            mvvl_pkg::CORE_IDLE: begin
                s_ready = 1'b1;
                accept  = s_valid;
                if (accept && (s_data.req_type == mvvl_pkg::REQ_TICK)) begin
                    lane_ctrl.start = 1'b1;
                    state_next      = mvvl_pkg::CORE_BUSY;
                end else if (accept) begin
                    lane_ctrl.load  = 1'b1;
                    merge_ctrl.load = 1'b1;
                end
            end
            mvvl_pkg::CORE_BUSY: begin
                if (all_done && out_free) begin
                    lane_ctrl.commit  = 1'b1;
                    merge_ctrl.commit = 1'b1;
                    state_next        = mvvl_pkg::CORE_IDLE;
                end
            end
            default: state_next = mvvl_pkg::CORE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mvvl_pkg::CORE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    for (genvar g = 0; g < mvvl_pkg::MOTOR_COUNT; g++) begin : g_lane
        mvvl_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cfg        (cfg_reg),
            .ctrl       (lane_ctrl),
            .target_vel (target_vel[g]),
            .meas_vel   (meas_vel[g]),
            .result     (lane_res[g])
        );
    end

    mvvl_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (merge_ctrl),
        .timeout_ticks (cfg_reg.timeout_ticks),
        .lane_res      (lane_res),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_data        (m_data),
        .kill          (kill),
        .out_free      (out_free)
    );

endmodule

`default_nettype wire
